FILE: hw/rtl/dah_pkg.sv
// Shared types and constants for the d-ary min-heap block.
// Used by the controller, the datapath and the top level; depends on nothing.
package dah_pkg;

	// arity register width and its meaningful range
	localparam int D_W       = 4;
	localparam int ARITY_MIN = 2;
	localparam int ARITY_MAX = 8;

	// request opcodes
	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_HEAPIFY = 2'd1,
		OP_DELETE  = 2'd2,
		OP_INSERT  = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} res_status_t;

	// memory read address source
	typedef enum logic [2:0] {
		RD_ZERO   = 3'd0,
		RD_LAST   = 3'd1,
		RD_FIRST  = 3'd2,
		RD_SCAN   = 3'd3,
		RD_IDX    = 3'd4,
		RD_PARENT = 3'd5
	} rd_sel_t;

	// memory write source
	typedef enum logic [2:0] {
		WR_NONE   = 3'd0,
		WR_LOAD   = 3'd1,
		WR_KN     = 3'd2,
		WR_BEST   = 3'd3,
		WR_PARENT = 3'd4
	} wr_sel_t;

	// current node register source
	typedef enum logic [2:0] {
		NODE_HOLD   = 3'd0,
		NODE_ZERO   = 3'd1,
		NODE_IDX    = 3'd2,
		NODE_BEST   = 3'd3,
		NODE_PARENT = 3'd4,
		NODE_CNT    = 3'd5
	} node_sel_t;

	// moving key register source
	typedef enum logic [1:0] {
		KN_HOLD = 2'd0,
		KN_KEY  = 2'd1,
		KN_RD   = 2'd2
	} kn_sel_t;

	// key count update
	typedef enum logic [1:0] {
		CNT_HOLD = 2'd0,
		CNT_INC  = 2'd1,
		CNT_DEC  = 2'd2
	} cnt_op_t;

	// controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_DEL_A,
		S_DEL_B,
		S_HF_RD,
		S_HF_LD,
		S_DN_START,
		S_DN_SCAN,
		S_DN_DEC,
		S_UP_CHK,
		S_UP_DIV,
		S_UP_CMP,
		S_RESP
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		rd_sel_t     rd_sel;
		wr_sel_t     wr_sel;
		node_sel_t   node_sel;
		kn_sel_t     kn_sel;
		cnt_op_t     cnt_op;
		logic        hf_start;
		logic        i_dec;
		logic        min_latch;
		logic        dn_start;
		logic        scan_step;
		logic        div_start;
		logic        resp_load;
		res_status_t resp_status;
		logic        resp_mv;
	} dah_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic no_child;
		logic scan_last;
		logic less;
		logic node_zero;
		logic par_greater;
		logic i_zero;
		logic div_done;
	} dah_stat_t;

endpackage

FILE: hw/rtl/dah_div.sv
// Bit-serial restoring divider for the parent index (node - 1) / arity.
// One quotient bit per cycle; depends on nothing.
module dah_div #(
	parameter int N = 6
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [N-1:0] dividend,
	input  logic [3:0]   divisor,
	output logic [N-1:0] quotient,
	output logic         done
);

	localparam int SW = $clog2(N + 1);

	logic [N-1:0]  quo_q;
	logic [3:0]    rem_q;
	logic [SW-1:0] step_q;
	logic          busy_q;
	logic          done_q;

	logic [4:0]    rem_sh;
	logic          ge;
	logic [4:0]    rem_nx;
	logic [N:0]    quo_sh;

	// shift in the next dividend bit and trial-subtract
	always_comb begin
		rem_sh = {rem_q, quo_q[N-1]};
		ge     = rem_sh >= {1'b0, divisor};
		rem_nx = ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
		quo_sh = {quo_q, ge};
	end

	// advance one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= SW'(N);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == SW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= quo_sh[N-1:0];
			rem_q <= rem_nx[3:0];
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

FILE: hw/rtl/dah_datapath.sv
// Datapath of the d-ary min-heap: key memory, key count, sift registers, result register.
// Depends on dah_pkg and dah_div.
module dah_datapath #(
	parameter int CAPACITY = 64,
	parameter int KEY_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [dah_pkg::D_W-1:0]        d,
	input  logic [KEY_BITS-1:0]            key_in,
	input  dah_pkg::dah_cmd_t              cmd,
	output dah_pkg::dah_stat_t             stat,
	output logic [31:0]                    min_key,
	output logic                           min_valid,
	output logic [$clog2(CAPACITY+1)-1:0]  count,
	output logic [1:0]                     status
);

	import dah_pkg::*;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int EXT_W = IDX_W + D_W;

	logic [KEY_BITS-1:0] mem [CAPACITY];

	logic [CNT_W-1:0]    cnt_q;
	logic [IDX_W-1:0]    node_q;
	logic [KEY_BITS-1:0] kn_q;
	logic [KEY_BITS-1:0] best_key_q;
	logic [IDX_W-1:0]    best_idx_q;
	logic [IDX_W-1:0]    first_q;
	logic [IDX_W-1:0]    last_q;
	logic [IDX_W-1:0]    scan_q;
	logic [IDX_W-1:0]    i_q;
	logic [KEY_BITS-1:0] min_key_q;
	logic [KEY_BITS-1:0] rd_q;
	logic [IDX_W-1:0]    rd_idx_q;

	logic [31:0]         res_key_q;
	logic                res_mv_q;
	logic [CNT_W-1:0]    res_cnt_q;
	res_status_t         res_st_q;

	logic [EXT_W-1:0]    prod;
	logic [EXT_W-1:0]    first_x;
	logic [EXT_W-1:0]    lastc_x;
	logic [EXT_W-1:0]    cnt_x;
	logic [EXT_W-1:0]    cntm1_x;
	logic [EXT_W-1:0]    last_x;

	logic [IDX_W-1:0]    rd_addr;
	logic                we;
	logic [IDX_W-1:0]    waddr;
	logic [KEY_BITS-1:0] wdata;

	logic [IDX_W-1:0]    parent;
	logic                div_done;

	// parent index of the current node
	dah_div #(
		.N(IDX_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (node_q - 1'b1),
		.divisor  (d),
		.quotient (parent),
		.done     (div_done)
	);

	// child range of the current node
	always_comb begin
		prod    = EXT_W'(node_q) * EXT_W'(d);
		first_x = prod + 1'b1;
		lastc_x = prod + EXT_W'(d);
		cnt_x   = EXT_W'(cnt_q);
		cntm1_x = cnt_x - 1'b1;
		last_x  = (lastc_x > cntm1_x) ? cntm1_x : lastc_x;
	end

	// select read address
	always_comb begin
		case (cmd.rd_sel)
			RD_ZERO:   rd_addr = '0;
			RD_LAST:   rd_addr = IDX_W'(cnt_q - 1'b1);
			RD_FIRST:  rd_addr = IDX_W'(first_x);
			RD_SCAN:   rd_addr = scan_q;
			RD_IDX:    rd_addr = i_q;
			RD_PARENT: rd_addr = parent;
			default:   rd_addr = '0;
		endcase
	end

	// select write port
	always_comb begin
		we    = 1'b1;
		waddr = node_q;
		wdata = kn_q;
		case (cmd.wr_sel)
			WR_NONE:   we = 1'b0;
			WR_LOAD: begin
				waddr = IDX_W'(cnt_q);
				wdata = key_in;
			end
			WR_KN:     wdata = kn_q;
			WR_BEST:   wdata = best_key_q;
			WR_PARENT: wdata = rd_q;
			default:   we = 1'b0;
		endcase
	end

	// key memory with registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q     <= mem[rd_addr];
		rd_idx_q <= rd_addr;
	end

	// key count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (cmd.cnt_op)
				CNT_INC:  cnt_q <= cnt_q + 1'b1;
				CNT_DEC:  cnt_q <= cnt_q - 1'b1;
				default:  cnt_q <= cnt_q;
			endcase
		end
	end

	// sift registers
	always_ff @(posedge clk) begin
		case (cmd.node_sel)
			NODE_ZERO:   node_q <= '0;
			NODE_IDX:    node_q <= i_q;
			NODE_BEST:   node_q <= best_idx_q;
			NODE_PARENT: node_q <= rd_idx_q;
			NODE_CNT:    node_q <= IDX_W'(cnt_q);
			default:     node_q <= node_q;
		endcase
		case (cmd.kn_sel)
			KN_KEY:  kn_q <= key_in;
			KN_RD:   kn_q <= rd_q;
			default: kn_q <= kn_q;
		endcase
		if (cmd.hf_start) begin
			i_q <= IDX_W'(cnt_q - 1'b1);
		end else if (cmd.i_dec) begin
			i_q <= i_q - 1'b1;
		end
		if (cmd.min_latch) begin
			min_key_q <= rd_q;
		end
		if (cmd.dn_start) begin
			first_q <= IDX_W'(first_x);
			last_q  <= IDX_W'(last_x);
			scan_q  <= IDX_W'(first_x + 1'b1);
		end else if (cmd.scan_step) begin
			scan_q <= scan_q + 1'b1;
		end
		// keep the smallest child, lowest index on ties
		if (cmd.scan_step && ((rd_idx_q == first_q) || (rd_q < best_key_q))) begin
			best_key_q <= rd_q;
			best_idx_q <= rd_idx_q;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.resp_load) begin
			res_key_q <= cmd.resp_mv ? 32'(min_key_q) : 32'd0;
			res_mv_q  <= cmd.resp_mv;
			res_cnt_q <= cnt_q;
			res_st_q  <= cmd.resp_status;
		end
	end

	// status toward the controller
	always_comb begin
		stat.full        = cnt_q == CNT_W'(CAPACITY);
		stat.empty       = cnt_q == '0;
		stat.no_child    = first_x >= cnt_x;
		stat.scan_last   = rd_idx_q == last_q;
		stat.less        = best_key_q < kn_q;
		stat.node_zero   = node_q == '0;
		stat.par_greater = rd_q > kn_q;
		stat.i_zero      = i_q == '0;
		stat.div_done    = div_done;
	end

	assign min_key   = res_key_q;
	assign min_valid = res_mv_q;
	assign count     = res_cnt_q;
	assign status    = res_st_q;

endmodule

FILE: hw/rtl/dah_ctrl.sv
// Controller of the d-ary min-heap: request sequencing and output handshake.
// Depends on dah_pkg.
module dah_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  dah_pkg::op_t       opcode,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  dah_pkg::dah_stat_t stat,
	output dah_pkg::dah_cmd_t  cmd
);

	import dah_pkg::*;

	state_t      state_q;
	state_t      state_d;
	op_t         op_q;
	res_status_t status_q;
	logic        mv_q;
	logic        out_valid_q;

	logic        accept;
	logic        sift_done;
	logic        hf_more;
	logic        resp_go;

	always_comb begin
		accept    = (state_q == S_IDLE) && in_valid;
		hf_more   = (op_q == OP_HEAPIFY) && !stat.i_zero;
		sift_done = ((state_q == S_DN_START) && stat.no_child) ||
		            ((state_q == S_DN_DEC) && !stat.less);
		resp_go   = (state_q == S_RESP) && (!out_valid_q || !out_stall);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (opcode)
						OP_LOAD:    state_d = S_RESP;
						OP_INSERT:  state_d = stat.full ? S_RESP : S_UP_CHK;
						OP_HEAPIFY: state_d = stat.empty ? S_RESP : S_HF_RD;
						OP_DELETE:  state_d = stat.empty ? S_RESP : S_DEL_A;
						default:    state_d = S_RESP;
					endcase
				end
			end
			S_DEL_A:    state_d = S_DEL_B;
			S_DEL_B:    state_d = S_DN_START;
			S_HF_RD:    state_d = S_HF_LD;
			S_HF_LD:    state_d = S_DN_START;
			S_DN_START: begin
				if (stat.no_child) begin
					state_d = hf_more ? S_HF_RD : S_RESP;
				end else begin
					state_d = S_DN_SCAN;
				end
			end
			S_DN_SCAN:  state_d = stat.scan_last ? S_DN_DEC : S_DN_SCAN;
			S_DN_DEC: begin
				if (stat.less) begin
					state_d = S_DN_START;
				end else begin
					state_d = hf_more ? S_HF_RD : S_RESP;
				end
			end
			S_UP_CHK:   state_d = stat.node_zero ? S_RESP : S_UP_DIV;
			S_UP_DIV:   state_d = stat.div_done ? S_UP_CMP : S_UP_DIV;
			S_UP_CMP:   state_d = stat.par_greater ? S_UP_CHK : S_RESP;
			S_RESP:     state_d = resp_go ? S_IDLE : S_RESP;
			default:    state_d = S_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd             = '0;
		cmd.resp_status = status_q;
		cmd.resp_mv     = mv_q;
		if (sift_done) begin
			cmd.wr_sel = WR_KN;
			cmd.i_dec  = hf_more;
		end
		case (state_q)
			S_IDLE: begin
				cmd.rd_sel = RD_ZERO;
				if (accept && !stat.full && (opcode == OP_LOAD)) begin
					cmd.wr_sel = WR_LOAD;
					cmd.cnt_op = CNT_INC;
				end
				if (accept && !stat.full && (opcode == OP_INSERT)) begin
					cmd.node_sel = NODE_CNT;
					cmd.kn_sel   = KN_KEY;
					cmd.cnt_op   = CNT_INC;
				end
				if (accept && (opcode == OP_HEAPIFY)) begin
					cmd.hf_start = 1'b1;
				end
			end
			S_DEL_A: begin
				cmd.min_latch = 1'b1;
				cmd.rd_sel    = RD_LAST;
				cmd.cnt_op    = CNT_DEC;
			end
			S_DEL_B: begin
				cmd.kn_sel   = KN_RD;
				cmd.node_sel = NODE_ZERO;
			end
			S_HF_RD: cmd.rd_sel = RD_IDX;
			S_HF_LD: begin
				cmd.kn_sel   = KN_RD;
				cmd.node_sel = NODE_IDX;
			end
			S_DN_START: begin
				if (!stat.no_child) begin
					cmd.rd_sel   = RD_FIRST;
					cmd.dn_start = 1'b1;
				end
			end
			S_DN_SCAN: begin
				cmd.rd_sel    = RD_SCAN;
				cmd.scan_step = 1'b1;
			end
			S_DN_DEC: begin
				if (stat.less) begin
					cmd.wr_sel   = WR_BEST;
					cmd.node_sel = NODE_BEST;
				end
			end
			S_UP_CHK: begin
				if (stat.node_zero) begin
					cmd.wr_sel = WR_KN;
				end else begin
					cmd.div_start = 1'b1;
				end
			end
			S_UP_DIV: cmd.rd_sel = RD_PARENT;
			S_UP_CMP: begin
				if (stat.par_greater) begin
					cmd.wr_sel   = WR_PARENT;
					cmd.node_sel = NODE_PARENT;
				end else begin
					cmd.wr_sel = WR_KN;
				end
			end
			S_RESP: cmd.resp_load = resp_go;
			default: cmd.rd_sel = RD_ZERO;
		endcase
	end

	// state, request type and result flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_LOAD;
			status_q    <= ST_DONE;
			mv_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				op_q <= opcode;
				if (stat.full && ((opcode == OP_LOAD) || (opcode == OP_INSERT))) begin
					status_q <= ST_FULL;
				end else if (stat.empty && (opcode == OP_DELETE)) begin
					status_q <= ST_EMPTY;
				end else begin
					status_q <= ST_DONE;
				end
				mv_q <= (opcode == OP_DELETE) && !stat.empty;
			end
			// hold the result until taken
			if (resp_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;

endmodule

FILE: hw/rtl/d_ary_min_heap.sv
// d-ary min-heap of unsigned keys, CAPACITY entries of KEY_BITS bits.
// Input channel (in_valid/in_stall, opcode, key): one request per item:
// load, heapify, delete-min or insert. Output channel (out_valid/out_stall):
// one result per request with min_key, min_valid, count and status.
// The arity register (children per node, 2..8, values outside are clamped)
// is written through the APB port, where every address selects it; the user
// writes it only while the block is idle, which the block does not enforce.
// A request is taken only while the controller is idle; the result waits in
// an output register, so the next request is taken while it is still held.
// Insert sifts the key up by parent compares until it reaches the root or a
// parent that is not greater; delete takes the root key and sifts the last
// key down from the root; heapify runs one sift-down per entry, last first.
// Sift-down reads one child a cycle from the single-read heap memory; sift-up
// waits on the bit-serial parent-index divider, one bit per cycle.
// At reset the heap is empty, arity is 2 and no result is pending; the key
// memory is not cleared. While out_stall is high the result holds and a
// finished request waits in the controller before loading it.
// Depends on dah_pkg, dah_ctrl, dah_datapath and dah_div.
module d_ary_min_heap #(
	parameter int CAPACITY = 64,
	parameter int KEY_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [1:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    opcode,
	input  logic [31:0]                   key,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [31:0]                   min_key,
	output logic                          min_valid,
	output logic [$clog2(CAPACITY+1)-1:0] count,
	output logic [1:0]                    status
);

	import dah_pkg::*;

	logic [D_W-1:0] arity_q;
	logic [D_W-1:0] d_eff;
	dah_cmd_t       cmd;
	dah_stat_t      stat;

	// arity register, single register so every address selects it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arity_q <= D_W'(ARITY_MIN);
		end else if (psel && penable && pwrite && pready && (paddr[1:0] == 2'd0 ||
		             paddr[1:0] != 2'd0)) begin
			arity_q <= pwdata[D_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = 32'(arity_q);

	// clamp arity to its meaningful range
	always_comb begin
		if (arity_q < D_W'(ARITY_MIN)) begin
			d_eff = D_W'(ARITY_MIN);
		end else if (arity_q > D_W'(ARITY_MAX)) begin
			d_eff = D_W'(ARITY_MAX);
		end else begin
			d_eff = arity_q;
		end
	end

	dah_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.opcode    (op_t'(opcode)),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	dah_datapath #(
		.CAPACITY(CAPACITY),
		.KEY_BITS(KEY_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.d         (d_eff),
		.key_in    (KEY_BITS'(key)),
		.cmd       (cmd),
		.stat      (stat),
		.min_key   (min_key),
		.min_valid (min_valid),
		.count     (count),
		.status    (status)
	);

`ifndef ASSERT_OFF
	// count stays within the store
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (count <= CAPACITY))
		else $error("count above capacity");

	// a removed minimum only comes with a done status
	a_min_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && min_valid) |-> (status == ST_DONE))
		else $error("min_valid with non-done status");

	// a full refusal reports a full heap
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_FULL)) |-> (count == CAPACITY))
		else $error("full status without full heap");

	// an empty delete reports no keys and no minimum
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_EMPTY)) |-> ((count == 0) && !min_valid && (min_key == 0)))
		else $error("empty status with keys or minimum");
`endif

endmodule

FILE: sim/d_ary_min_heap_chk.sv
// Checker for the d-ary min-heap: watches the APB port and both request channels,
// keeps its own copy of the heap to predict each result, and compares field by field.
// Depends on dah_pkg for the opcode and status codes.
module d_ary_min_heap_chk #(
	parameter int CAPACITY = 64,
	parameter logic [1:0] REG_ARITY = 2'd0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic                          pready,
	input  logic [1:0]                    paddr,
	input  logic [31:0]                   pwdata,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [1:0]                    opcode,
	input  logic [31:0]                   key,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [31:0]                   min_key,
	input  logic                          min_valid,
	input  logic [$clog2(CAPACITY+1)-1:0] count,
	input  logic [1:0]                    status,
	output int                            errors,
	output int                            pending
);
	import dah_pkg::*;

	localparam int CW = $clog2(CAPACITY+1);

	typedef struct packed {
		logic [31:0] min_key;
		logic        min_valid;
		logic [CW-1:0] count;
		res_status_t status;
	} heap_result_t;

	// shadow heap: keys, number held and the arity register
	logic [31:0]   heap_mem [CAPACITY];
	int unsigned   held;
	logic [D_W-1:0] arity_reg;
	heap_result_t  expected_q [$];
	heap_result_t  want;

	// clamp the arity register to its meaningful range
	function automatic int unsigned fanout();
		if (arity_reg < ARITY_MIN) return ARITY_MIN;
		if (arity_reg > ARITY_MAX) return ARITY_MAX;
		return arity_reg;
	endfunction

	function automatic void swap_keys(int unsigned a, int unsigned b);
		logic [31:0] t;
		t = heap_mem[a];
		heap_mem[a] = heap_mem[b];
		heap_mem[b] = t;
	endfunction

	// push a node down while its smallest child is strictly smaller;
	// equal children resolve to the lowest index
	function automatic void sift_down(int unsigned node, int unsigned d);
		int unsigned first, last, c, i;
		bit go;
		go = 1'b1;
		while (go) begin
			first = node * d + 1;
			if (first >= held) begin
				go = 1'b0;
			end else begin
				last = node * d + d;
				if (last > held - 1) last = held - 1;
				c = first;
				for (i = first + 1; i <= last; i++)
					if (heap_mem[i] < heap_mem[c]) c = i;
				if (heap_mem[c] < heap_mem[node]) begin
					swap_keys(c, node);
					node = c;
				end else begin
					go = 1'b0;
				end
			end
		end
	endfunction

	// move a node up while its parent is strictly greater
	function automatic void sift_up(int unsigned node, int unsigned d);
		int unsigned p;
		bit go;
		go = 1'b1;
		while (go && node > 0) begin
			p = (node - 1) / d;
			if (heap_mem[p] > heap_mem[node]) begin
				swap_keys(p, node);
				node = p;
			end else begin
				go = 1'b0;
			end
		end
	endfunction

	// apply one request to the shadow heap and return the result it yields
	function automatic heap_result_t apply_request(op_t op, logic [31:0] k);
		heap_result_t r;
		int unsigned d, i;
		d = fanout();
		r.min_key = '0;
		r.min_valid = 1'b0;
		r.status = ST_DONE;
		case (op)
			OP_LOAD, OP_INSERT: begin
				if (held >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					heap_mem[held] = k;
					held++;
					if (op == OP_INSERT) sift_up(held - 1, d);
				end
			end
			OP_HEAPIFY: begin
				for (i = held; i > 0; i--)
					sift_down(i - 1, d);
			end
			default: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.min_key = heap_mem[0];
					r.min_valid = 1'b1;
					swap_keys(0, held - 1);
					held--;
					sift_down(0, d);
				end
			end
		endcase
		r.count = CW'(held);
		return r;
	endfunction

	task automatic report(string msg);
		$display("%0t d_ary_min_heap mismatch: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] exp_val);
		if (got !== exp_val)
			report($sformatf("%s got %0h, expected %0h", name, got, exp_val));
	endtask

	// track config writes, predict each accepted request, check each accepted result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			arity_reg = D_W'(ARITY_MIN);
			expected_q.delete();
			errors = 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == REG_ARITY)
				arity_reg = pwdata[D_W-1:0];
			if (in_valid && !in_stall)
				expected_q.push_back(apply_request(op_t'(opcode), key));
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					report("result with no request outstanding");
				end else begin
					want = expected_q.pop_front();
					check_field("min_key", min_key, want.min_key);
					check_field("min_valid", 32'(min_valid), 32'(want.min_valid));
					check_field("count", 32'(count), 32'(want.count));
					check_field("status", 32'(status), 32'(want.status));
				end
			end
			pending <= expected_q.size();
		end
	end

endmodule

FILE: sim/d_ary_min_heap_tb.sv
// Testbench top for the d-ary min-heap: clock, reset, APB arity writes and request
// stimulus with random idling on both channels. Depends on dah_pkg, d_ary_min_heap
// and the checker d_ary_min_heap_chk.
module d_ary_min_heap_tb;
	import dah_pkg::*;

	localparam int CAPACITY = 64;
	localparam int CW = $clog2(CAPACITY+1);
	localparam logic [1:0] REG_ARITY = 2'd0;
	localparam int PHASE_LEN = 117;
	localparam int SETTLE = 16;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          psel = 1'b0;
	logic          penable = 1'b0;
	logic          pwrite = 1'b0;
	logic [1:0]    paddr = REG_ARITY;
	logic [31:0]   pwdata = '0;
	logic [31:0]   prdata;
	logic          pready;
	logic          in_valid = 1'b0;
	logic          in_stall;
	logic [1:0]    opcode = OP_LOAD;
	logic [31:0]   key = '0;
	logic          out_valid;
	logic          out_stall = 1'b0;
	logic [31:0]   min_key;
	logic          min_valid;
	logic [CW-1:0] count;
	logic [1:0]    status;
	int            errors;
	int            pending;

	bit            quiet = 1'b0;
	int unsigned   hold_left = 0;
	int unsigned   n_sent = 0;
	int unsigned   arity_plan [12] = '{8, 0, 3, 15, 5, 1, 4, 9, 6, 7, 2, 12};

	d_ary_min_heap #(.CAPACITY(CAPACITY), .KEY_BITS(32)) uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .key(key),
		.out_valid(out_valid), .out_stall(out_stall), .min_key(min_key),
		.min_valid(min_valid), .count(count), .status(status)
	);

	d_ary_min_heap_chk #(.CAPACITY(CAPACITY), .REG_ARITY(REG_ARITY)) chk (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .key(key),
		.out_valid(out_valid), .out_stall(out_stall), .min_key(min_key),
		.min_valid(min_valid), .count(count), .status(status),
		.errors(errors), .pending(pending)
	);

	always #1 clk = ~clk;

	// after each taken result, stall the next one by a random hold-off (none when quiet), counted only while it is valid
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left = 0;
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall)
				hold_left = quiet ? 0 : $urandom_range(0, 3);
			else if (out_valid && hold_left > 0)
				hold_left--;
			out_stall <= (hold_left != 0);
		end
	end

	// mostly wide random keys, with extremes and a narrow range that forces ties
	function automatic logic [31:0] pick_key();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
			1, 2, 3: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	// idle for a random gap (none when quiet), then present one request and hold it until taken
	task automatic send_req(op_t op, logic [31:0] k);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		key <= k;
		do @(posedge clk); while (in_stall);
		n_sent++;
	endtask

	// drop valid and wait until every result is back and the block has settled
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// APB setup and access cycles; upper data bits are don't-care
	task automatic write_arity(logic [D_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_ARITY;
		pwdata <= ($urandom & 32'hFFFF_FFF0) | 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// random op mix: thresholds out of 100 for insert, load, heapify; rest delete
	task automatic run_mix(int unsigned stop_at, int unsigned ins_th, int unsigned ld_th,
			int unsigned hf_th);
		int unsigned r;
		while (n_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < ins_th) send_req(OP_INSERT, pick_key());
			else if (r < ld_th) send_req(OP_LOAD, pick_key());
			else if (r < hf_th) send_req(OP_HEAPIFY, $urandom);
			else send_req(OP_DELETE, $urandom);
		end
	endtask

	// load a batch, heapify it (usually), sometimes insert one more key, then drain it and a little more
	task automatic run_batches(int unsigned stop_at);
		int unsigned n;
		while (n_sent < stop_at) begin
			n = $urandom_range(1, 20);
			repeat (n) send_req(OP_LOAD, pick_key());
			if ($urandom_range(0, 3) != 0) send_req(OP_HEAPIFY, $urandom);
			if ($urandom_range(0, 4) == 0) send_req(OP_INSERT, pick_key());
			repeat (n + $urandom_range(0, 3)) send_req(OP_DELETE, $urandom);
		end
	endtask

	initial begin
		int unsigned p;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty heap, extremes, unordered loads, ties, drain past empty
		send_req(OP_DELETE, 32'hFFFF_FFFF);
		send_req(OP_HEAPIFY, 32'h0);
		send_req(OP_LOAD, 32'hFFFF_FFFF);
		send_req(OP_LOAD, 32'h0);
		send_req(OP_LOAD, 32'd5);
		send_req(OP_LOAD, 32'd5);
		send_req(OP_HEAPIFY, 32'hA5A5_5A5A);
		send_req(OP_DELETE, 32'h5A5A_A5A5);
		send_req(OP_INSERT, 32'h0);
		send_req(OP_INSERT, 32'hFFFF_FFFF);
		send_req(OP_INSERT, 32'd3);
		send_req(OP_INSERT, 32'd3);
		send_req(OP_DELETE, 32'h0);
		send_req(OP_DELETE, 32'h0);
		send_req(OP_LOAD, 32'd1);
		send_req(OP_HEAPIFY, 32'h0);
		repeat (7) send_req(OP_DELETE, $urandom);

		// random phases, one arity setting each; fill to full, batch, drain to empty
		for (p = 0; p < 12; p++) begin
			wait_idle();
			write_arity(D_W'(arity_plan[p]));
			quiet = (p % 4 == 3);
			case (p % 3)
				0: run_mix(n_sent + PHASE_LEN, 55, 80, 85);
				1: run_batches(n_sent + PHASE_LEN);
				default: run_mix(n_sent + PHASE_LEN, 10, 15, 20);
			endcase
		end
		quiet = 1'b0;
		wait_idle();

		if (errors == 0)
			$display("d_ary_min_heap_tb: done, clean");
		else
			$display("d_ary_min_heap_tb: done, errors");
		$finish;
	end

	// hang guard
	initial begin
		#5_000_000;
		$display("d_ary_min_heap_tb: done, errors");
		$finish;
	end

endmodule
